FILE: rtl/core/uri_percent_decoder_top_assert.svh
// Assertion macros for the URI percent decoder top level.
`ifndef URI_PERCENT_DECODER_TOP_ASSERT_SVH
`define URI_PERCENT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/upd_pkg.sv
// Shared types and constants of the URI percent decoder.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } upd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
        logic       malformed;
    } upd_out_t;

    // Escape parser phase.
    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_PCT,
        PH_HEX1
    } upd_phase_t;

    // One job handed from the front to the back: up to four result bytes.
    // cnt holds the number of bytes minus one; bytes[0] goes out first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
        logic            malformed;
    } upd_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } upd_qstat_t;

endpackage

FILE: rtl/core/upd_front.sv
// Front end: accepts input beats, parses escapes and UTF-8 sequences, builds jobs.
`timescale 1ns / 1ps

module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  upd_in_t    in_data,
    input  upd_qstat_t q_stat,
    output logic       push,
    output upd_job_t   push_job
);

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            if (c >= 8'h30 && c <= 8'h39) begin
                r = 5'(c - 8'h30);
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = 5'(c - 8'h41 + 8'd10);
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = 5'(c - 8'h61 + 8'd10);
            end else begin
                r = 5'd16;
            end
            return r;
        end
    endfunction

    function automatic logic is_reserved(input logic [7:0] v);
        begin
            return v == 8'h3B || v == 8'h2F || v == 8'h3F || v == 8'h3A ||
                   v == 8'h40 || v == 8'h26 || v == 8'h3D || v == 8'h2B ||
                   v == 8'h24 || v == 8'h2C || v == 8'h23;
        end
    endfunction

    function automatic logic is_cont(input logic [7:0] v);
        begin
            return v[7:6] == 2'b10;
        end
    endfunction

    // Well-formedness of a complete sequence of n bytes.
    function automatic logic seq_ok(input logic [3:0][7:0] s, input logic [2:0] n);
        logic [20:0] cp;
        logic        ok;
        begin
            cp = '0;
            ok = 1'b0;
            case (n)
                3'd2: begin
                    cp = {10'd0, s[0][4:0], s[1][5:0]};
                    ok = is_cont(s[1]) && cp >= 21'h80;
                end
                3'd3: begin
                    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
                    ok = is_cont(s[1]) && is_cont(s[2]) && cp >= 21'h800 &&
                         (cp < 21'hD800 || cp > 21'hDFFF);
                end
                3'd4: begin
                    cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
                    ok = is_cont(s[1]) && is_cont(s[2]) && is_cont(s[3]) &&
                         cp >= 21'h10000 && cp <= 21'h10FFFF;
                end
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    logic            preserve_reg;
    upd_phase_t      phase_reg, phase_next;
    logic [7:0]      first_reg, first_next;
    logic [3:0][7:0] seq_reg, seq_next;
    logic [2:0]      count_reg, count_next;
    logic [1:0]      cont_reg, cont_next;
    logic            discard_reg, discard_next;

    logic            accept;
    logic [7:0]      b;
    logic            last;
    logic [4:0]      hv_b;
    logic [4:0]      hv_first;
    logic [7:0]      v;
    logic [3:0][7:0] seq_cur;
    logic            fail;
    logic            emit;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.in_byte;
    assign last     = in_data.in_last;
    assign hv_b     = hex_value(b);
    assign hv_first = hex_value(first_reg);
    assign v        = {hv_first[3:0], hv_b[3:0]};

    // Sequence bytes as they stand once the current escape is stored.
    always_comb
    begin
        seq_cur = seq_reg;
        seq_cur[count_reg[1:0]] = v;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        seq_next     = seq_reg;
        count_next   = count_reg;
        cont_next    = cont_reg;
        discard_next = discard_reg;
        fail         = 1'b0;
        emit         = 1'b0;
        push_job     = '0;
        push_job.last = last;

        if (accept) begin
            if (discard_reg) begin
                if (last) begin
                    discard_next = 1'b0;
                end
            end else begin
                unique case (phase_reg)
                    PH_PLAIN: begin
                        if (b != PERCENT_CHAR) begin
                            if (cont_reg != 2'd0) begin
                                fail = 1'b1;
                            end else begin
                                emit = 1'b1;
                                push_job.bytes[0] = b;
                            end
                        end else begin
                            phase_next = PH_PCT;
                            fail = last;
                        end
                    end
                    PH_PCT: begin
                        if (hv_b[4] || last) begin
                            fail = 1'b1;
                        end else begin
                            first_next = b;
                            phase_next = PH_HEX1;
                        end
                    end
                    PH_HEX1: begin
                        if (hv_b[4]) begin
                            fail = 1'b1;
                        end else begin
                            phase_next = PH_PLAIN;
                            if (cont_reg != 2'd0) begin
                                seq_next   = seq_cur;
                                count_next = count_reg + 3'd1;
                                cont_next  = cont_reg - 2'd1;
                                if (cont_reg == 2'd1) begin
                                    if (!seq_ok(seq_cur, count_reg + 3'd1)) begin
                                        fail = 1'b1;
                                    end else begin
                                        emit = 1'b1;
                                        push_job.bytes = seq_cur;
                                        push_job.cnt   = count_reg[1:0];
                                        count_next     = 3'd0;
                                    end
                                end else begin
                                    fail = last;
                                end
                            end else if (!v[7]) begin
                                emit = 1'b1;
                                if (preserve_reg && is_reserved(v)) begin
                                    push_job.bytes[0] = PERCENT_CHAR;
                                    push_job.bytes[1] = first_reg;
                                    push_job.bytes[2] = b;
                                    push_job.cnt      = 2'd2;
                                end else begin
                                    push_job.bytes[0] = v;
                                end
                            end else begin
                                // Lead byte: its leading ones give the length.
                                seq_next[0] = v;
                                count_next  = 3'd1;
                                fail        = last;
                                if (v[7:5] == 3'b110) begin
                                    cont_next = 2'd1;
                                end else if (v[7:4] == 4'b1110) begin
                                    cont_next = 2'd2;
                                end else if (v[7:3] == 5'b11110) begin
                                    cont_next = 2'd3;
                                end else begin
                                    fail = 1'b1;
                                end
                            end
                        end
                    end
                    default: phase_next = PH_PLAIN;
                endcase

                if (fail) begin
                    push_job           = '0;
                    push_job.last      = 1'b1;
                    push_job.malformed = 1'b1;
                end

                if (fail || (emit && last)) begin
                    phase_next   = PH_PLAIN;
                    first_next   = '0;
                    count_next   = '0;
                    cont_next    = '0;
                    discard_next = fail && !last;
                end
            end
        end
    end

    assign push = accept && (fail || emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            preserve_reg <= 1'b0;
            phase_reg    <= PH_PLAIN;
            first_reg    <= '0;
            count_reg    <= '0;
            cont_reg     <= '0;
            discard_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                preserve_reg <= cfg_data;
            end
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            count_reg   <= count_next;
            cont_reg    <= cont_next;
            discard_reg <= discard_next;
        end
    end

    // Sequence bytes are only read after being written in the same sequence.
    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
    end

endmodule

FILE: rtl/core/upd_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module upd_queue
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  upd_job_t   push_job,
    input  logic       pop,
    output upd_job_t   head_job,
    output upd_qstat_t stat
);

    upd_job_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_AW:0]   level_reg, level_next;

    assign stat.full  = level_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign stat.empty = level_reg == '0;
    assign head_job   = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/upd_back.sv
// Back end: unrolls queued jobs into output beats behind an output register.
`timescale 1ns / 1ps

module upd_back
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  upd_job_t   head_job,
    input  upd_qstat_t q_stat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output upd_out_t   out_data
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    upd_out_t   data_reg, data_next;
    logic       load;
    logic       final_byte;

    assign load       = !q_stat.empty && (!valid_reg || out_ready);
    assign final_byte = idx_reg == head_job.cnt;
    assign pop        = load && final_byte;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next              = 1'b1;
            data_next.out_byte      = head_job.bytes[idx_reg];
            data_next.end_of_string = head_job.last && final_byte;
            data_next.malformed     = head_job.malformed;
            idx_next                = final_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/uri_percent_decoder_top.sv
// Top level of the streaming URI percent decoder.
//
//   Channel   Direction  Handshake             Beat contents
//   cfg       in         cfg_valid/cfg_ready   cfg_data: preserve_reserved
//   in        in         in_valid/in_ready     in_data: in_byte, in_last
//   out       out        out_valid/out_ready   out_data: out_byte, end_of_string, malformed
//
// One input beat is taken every cycle while the four-entry job queue has room.
// An input beat that yields results is written as a job into the queue, then
// loaded into the output register, which sends one result beat per cycle while
// out_ready allows; a preserved reserved escape or a UTF-8 sequence keeps it busy
// for all of its bytes. That single-beat output register sets the result rate.
// rst_n clears all control state asynchronously; no clearing pass is needed.
// A stall on out_ready fills the queue, and only then is in_ready dropped.
`timescale 1ns / 1ps
`include "uri_percent_decoder_top_assert.svh"

module uri_percent_decoder_top
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data,
    input  logic     in_valid,
    output logic     in_ready,
    input  upd_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output upd_out_t out_data
);

    logic       q_push;
    logic       q_pop;
    upd_job_t   push_job;
    upd_job_t   head_job;
    upd_qstat_t q_stat;

    // The preserve_reserved register can take a write in any cycle.
    assign cfg_ready = 1'b1;

    // The front end parses escapes and validates UTF-8 sequences; each input
    // beat that produces output pushes one job of up to four bytes.
    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_job  (push_job)
    );

    // The queue lets the front keep taking beats while the back drains jobs.
    upd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // The back end walks the bytes of the head job into the output register.
    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A malformed result is a single zero byte that closes the string.
    `UPD_ASSERT_NOW(a_malformed_ends, out_valid && out_data.malformed,
        out_data.end_of_string && out_data.out_byte == 8'd0,
        "malformed beat must end the string with a zero byte")

    // A malformed job carries exactly one byte.
    `UPD_ASSERT_NOW(a_malformed_single, q_push && push_job.malformed,
        push_job.cnt == 2'd0 && push_job.last,
        "malformed job must hold one final byte")

    // Nothing reaches the output without a queued job behind it.
    `UPD_ASSERT_NEXT(a_no_phantom_beat, q_stat.empty && !out_valid,
        !out_valid, "output beat appeared with an empty queue")

endmodule

FILE: test/tb_uri_percent_decoder_top.sv
// Self-checking testbench for the streaming URI percent decoder top level.
`timescale 1ns / 1ps

module tb_uri_percent_decoder_top
    import upd_pkg::*;
();

    // Long receiver hold-off, in cycles, used once while the sender keeps going.
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    // Cycles allowed after the last expected result before a register write,
    // a margin for the front end and the queue to be idle.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES = 20;
    // Longest legal quiet stretch is the hold-off plus a settle; this is far above it.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 22;
    localparam int unsigned NUM_PHASES = 8;

    // Reference decoder plus the queue of decoded beats still owed by the block.
    class uri_decode_scoreboard;
        bit          preserve = 1'b0;
        upd_phase_t  esc_phase = PH_PLAIN;
        logic [7:0]  hi_char = '0;
        logic [7:0]  seq_buf [4];
        int unsigned seq_len = 0;
        int unsigned conts_left = 0;
        bit          dropping = 1'b0;
        upd_out_t    pending_bytes [$];
        int unsigned errors = 0;

        function int unsigned hex_val(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return 32'(c - "0");
            if (c >= "A" && c <= "F")
                return 32'(c - "A" + 8'd10);
            if (c >= "a" && c <= "f")
                return 32'(c - "a" + 8'd10);
            return 16;
        endfunction

        function bit is_reserved(logic [7:0] v);
            case (v)
                ";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#": return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function int unsigned lead_ones(logic [7:0] v);
            int unsigned n;
            n = 0;
            while (n < 8 && v[7 - n])
                n++;
            return n;
        endfunction

        // Well-formed UTF-8: right continuation bytes, no overlong form,
        // no surrogate, nothing above U+10FFFF.
        function bit utf8_ok();
            logic [31:0] cp;
            int unsigned i;
            if (seq_len < 2 || seq_len > 4)
                return 1'b0;
            for (i = 1; i < seq_len; i++)
                if (seq_buf[i][7:6] != 2'b10)
                    return 1'b0;
            case (seq_len)
                2: cp = {27'd0, seq_buf[0][4:0]};
                3: cp = {28'd0, seq_buf[0][3:0]};
                default: cp = {29'd0, seq_buf[0][2:0]};
            endcase
            for (i = 1; i < seq_len; i++)
                cp = (cp << 6) | {26'd0, seq_buf[i][5:0]};
            if (seq_len == 2)
                return cp >= 32'h80;
            if (seq_len == 3)
                return cp >= 32'h800 && (cp < 32'hD800 || cp > 32'hDFFF);
            return cp >= 32'h10000 && cp <= 32'h10FFFF;
        endfunction

        function void clear_string();
            esc_phase = PH_PLAIN;
            hi_char = '0;
            seq_len = 0;
            conts_left = 0;
            dropping = 1'b0;
        endfunction

        function upd_out_t data_beat(logic [7:0] b);
            return '{out_byte: b, end_of_string: 1'b0, malformed: 1'b0};
        endfunction

        // A malformed beat closes the string; the rest of it is dropped.
        function void reject(bit last);
            pending_bytes.push_back('{out_byte: 8'h00, end_of_string: 1'b1, malformed: 1'b1});
            clear_string();
            if (!last)
                dropping = 1'b1;
        endfunction

        function void take_encoded_byte(logic [7:0] b, bit last);
            upd_out_t    burst [$];
            int unsigned hi_val;
            int unsigned lo_val;
            int unsigned ones;
            int unsigned i;
            logic [7:0]  v;
            if (dropping)
            begin
                if (last)
                    clear_string();
                return;
            end
            case (esc_phase)
                PH_PLAIN:
                begin
                    if (b == PERCENT_CHAR)
                    begin
                        esc_phase = PH_PCT;
                        if (last)
                            reject(last);
                        return;
                    end
                    // A plain character cannot sit inside a UTF-8 sequence.
                    if (conts_left > 0)
                    begin
                        reject(last);
                        return;
                    end
                    burst.push_back(data_beat(b));
                end
                PH_PCT:
                begin
                    if (hex_val(b) > 15 || last)
                    begin
                        reject(last);
                        return;
                    end
                    hi_char = b;
                    esc_phase = PH_HEX1;
                    return;
                end
                default:
                begin
                    lo_val = hex_val(b);
                    if (lo_val > 15)
                    begin
                        reject(last);
                        return;
                    end
                    hi_val = hex_val(hi_char);
                    v = {hi_val[3:0], lo_val[3:0]};
                    esc_phase = PH_PLAIN;
                    if (conts_left > 0)
                    begin
                        // Any escaped byte counts as the next sequence byte.
                        seq_buf[seq_len % 4] = v;
                        seq_len = (seq_len + 1) % 8;
                        conts_left--;
                        if (conts_left == 0)
                        begin
                            if (!utf8_ok())
                            begin
                                reject(last);
                                return;
                            end
                            for (i = 0; i < seq_len && i < 4; i++)
                                burst.push_back(data_beat(seq_buf[i]));
                            seq_len = 0;
                        end
                        else
                        begin
                            if (last)
                                reject(last);
                            return;
                        end
                    end
                    else if (v < 8'h80)
                    begin
                        if (preserve && is_reserved(v))
                        begin
                            burst.push_back(data_beat(PERCENT_CHAR));
                            burst.push_back(data_beat(hi_char));
                            burst.push_back(data_beat(b));
                        end
                        else
                            burst.push_back(data_beat(v));
                    end
                    else
                    begin
                        ones = lead_ones(v);
                        if (ones == 1 || ones > 4)
                        begin
                            reject(last);
                            return;
                        end
                        seq_buf[0] = v;
                        seq_len = 1;
                        conts_left = ones - 1;
                        if (last)
                            reject(last);
                        return;
                    end
                end
            endcase
            if (last)
            begin
                if (burst.size() > 0)
                    burst[burst.size() - 1].end_of_string = 1'b1;
                clear_string();
            end
            foreach (burst[i])
                pending_bytes.push_back(burst[i]);
        endfunction

        function void check_decoded_beat(upd_out_t got);
            upd_out_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("result beat with nothing outstanding: out_byte %02h eos %0b malformed %0b",
                       got.out_byte, got.end_of_string, got.malformed);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.end_of_string !== want.end_of_string)
            begin
                $error("end_of_string: expected %0b, actual %0b",
                       want.end_of_string, got.end_of_string);
                errors++;
            end
            if (got.malformed !== want.malformed)
            begin
                $error("malformed: expected %0b, actual %0b", want.malformed, got.malformed);
                errors++;
            end
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    upd_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    upd_out_t out_data;

    uri_decode_scoreboard sb = new;

    logic [7:0]  text_q [$];
    int unsigned items_sent = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned rx_hold = 0;
    int unsigned quiet_cycles = 0;

    uri_percent_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Every handshake is observed at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.preserve = cfg_data;
            if (out_valid && out_ready)
                sb.check_decoded_beat(out_data);
            if (in_valid && in_ready)
                sb.take_encoded_byte(in_data.in_byte, in_data.in_last);
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: a requested hold-off first, otherwise random stalls.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function logic [7:0] hex_digit(logic [3:0] n);
        if (n < 10)
            return "0" + n;
        if ($urandom_range(0, 1))
            return 8'("A" + n - 10);
        return 8'("a" + n - 10);
    endfunction

    function void push_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function void push_escape(logic [7:0] v);
        text_q.push_back(PERCENT_CHAR);
        text_q.push_back(hex_digit(v[7:4]));
        text_q.push_back(hex_digit(v[3:0]));
    endfunction

    function void add_ascii_escape();
        string rsv_chars;
        logic [7:0] v;
        rsv_chars = ";/?:@&=+$,#";
        if ($urandom_range(0, 2) == 0)
            v = rsv_chars[$urandom_range(0, rsv_chars.len() - 1)];
        else
            v = 8'($urandom_range(0, 127));
        push_escape(v);
    endfunction

    function void add_valid_utf8();
        logic [31:0] cp;
        case ($urandom_range(2, 4))
            2:
            begin
                cp = $urandom_range(32'h80, 32'h7FF);
                push_escape({3'b110, cp[10:6]});
            end
            3:
            begin
                cp = $urandom_range(32'h800, 32'hFFFF);
                // Move surrogates out of the way.
                if (cp[15:11] == 5'b11011)
                    cp = cp ^ 32'h4000;
                push_escape({4'b1110, cp[15:12]});
                push_escape({2'b10, cp[11:6]});
            end
            default:
            begin
                cp = $urandom_range(32'h10000, 32'h10FFFF);
                push_escape({5'b11110, cp[20:18]});
                push_escape({2'b10, cp[17:12]});
                push_escape({2'b10, cp[11:6]});
            end
        endcase
        push_escape({2'b10, cp[5:0]});
    endfunction

    // Appends one broken construct; returns 1 when it must end the string.
    function bit add_error_token();
        logic [7:0] b;
        int unsigned n;
        int unsigned i;
        case ($urandom_range(0, 5))
            0:
            begin
                // A non-hex character where a digit belongs.
                text_q.push_back(PERCENT_CHAR);
                if ($urandom_range(0, 1))
                    text_q.push_back(hex_digit(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 3) == 0)
                    b = PERCENT_CHAR;
                else
                    do
                        b = 8'($urandom_range(0, 255));
                    while (sb.hex_val(b) < 16);
                text_q.push_back(b);
            end
            1:
            begin
                // Continuation byte or too many leading ones as a lead.
                if ($urandom_range(0, 1))
                    push_escape(8'($urandom_range(8'h80, 8'hBF)));
                else
                    push_escape(8'($urandom_range(8'hF8, 8'hFF)));
            end
            2:
            begin
                // A plain character breaks into an open sequence.
                push_escape(8'($urandom_range(8'hC2, 8'hF4)));
                do
                    b = 8'($urandom_range(0, 255));
                while (b == PERCENT_CHAR);
                text_q.push_back(b);
            end
            3:
            begin
                // Lead with mostly plausible continuations: overlong forms,
                // surrogates and out-of-range code points show up here.
                b = 8'($urandom_range(8'hC0, 8'hF7));
                n = (b >= 8'hF0) ? 3 : (b >= 8'hE0) ? 2 : 1;
                push_escape(b);
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 3) == 0)
                        push_escape(8'($urandom_range(0, 255)));
                    else
                        push_escape({2'b10, 6'($urandom_range(0, 63))});
            end
            4:
            begin
                // String ends with the sequence still open.
                push_escape(8'($urandom_range(8'hC2, 8'hF4)));
                return 1'b1;
            end
            default:
            begin
                // String ends inside an escape.
                text_q.push_back(PERCENT_CHAR);
                if ($urandom_range(0, 1))
                    text_q.push_back(hex_digit(4'($urandom_range(0, 15))));
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Mostly well-formed strings; roughly one token in seven is broken.
    function void build_random_string();
        int unsigned ntok;
        int unsigned t;
        int unsigned pick;
        logic [7:0] b;
        bit closed;
        ntok = $urandom_range(1, 6);
        closed = 1'b0;
        for (t = 0; t < ntok && !closed; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == PERCENT_CHAR)
                    b = 8'hA5;
                text_q.push_back(b);
            end
            else if (pick < 60)
                add_ascii_escape();
            else if (pick < 85)
                add_valid_utf8();
            else
                closed = add_error_token();
        end
    endfunction

    // Starts and ends at a falling edge; valid stays high between items unless an idle gap is drawn.
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= '{in_byte: b, in_last: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        int unsigned i;
        for (i = 0; i < text_q.size(); i++)
            send_item(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Sender pauses until every owed beat is out, then waits a settle margin for the front end.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_preserve(input logic val);
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned p;
        int unsigned phase_start;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings, decode-everything mode from reset.
        text_q.push_back(8'h00);
        push_str("%2f");
        text_q.push_back(8'hFF);
        send_text();
        push_str("%C3%a9");
        send_text();
        // Overlong two-byte form of NUL.
        push_str("%C0%80");
        send_text();
        // Escape cut short by the end of the string.
        push_str("%4");
        send_text();
        // Continuation byte as a lead; the trailing character is dropped.
        push_str("%80x");
        send_text();
        settle();
        write_preserve(1'b1);
        push_str("%3B");
        send_text();

        // Random phases: each idling pattern under both register settings.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_preserve(p[0]);
            case (p / 2)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 57;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 57;
                end
                default:
                begin
                    tx_idle_pct = 29;
                    rx_stall_pct = 29;
                end
            endcase
            // Back-pressure: the queue fills and the block stops taking input.
            if (p == 0)
                rx_hold = HOLD_OFF_CYCLES;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                build_random_string();
                send_text();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending_bytes.size() != 0)
        begin
            $error("%0d decoded beats never arrived", sb.pending_bytes.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: uri_percent_decoder_top.f
+incdir+rtl/core
rtl/core/upd_pkg.sv
rtl/core/upd_front.sv
rtl/core/upd_queue.sv
rtl/core/upd_back.sv
rtl/core/uri_percent_decoder_top.sv
test/tb_uri_percent_decoder_top.sv
